>>> sv/assert_macros.svh
// assertion macros used by ipv4_header_generate_top
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> sv/ihg_pkg.sv
// types and constants for the ipv4 header generator
// no dependencies
package ihg_pkg;

    typedef logic [31:0] addr_t;
    typedef logic [7:0]  proto_t;
    typedef logic [15:0] len_t;
    typedef logic [31:0] word_t;

    // header layout
    localparam int unsigned HDR_WORDS   = 5;
    localparam logic [7:0]  HDR_VER_IHL = 8'h45;
    localparam logic [7:0]  HDR_TOS     = 8'h00;
    localparam logic [15:0] HDR_BYTES   = 16'd20;
    localparam logic [15:0] HDR_ID      = 16'h0000;
    localparam logic [15:0] HDR_DF_FLAG = 16'h4000;
    localparam logic [7:0]  HDR_TTL     = 8'd64;

    // largest payload the link frame can carry
    localparam int unsigned MAX_PAYLOAD_DEF = 1518 - 20 - 8;

    // word position within the header transaction burst
    typedef logic [2:0] widx_t;
    localparam widx_t WIDX_LAST = widx_t'(HDR_WORDS - 1);

endpackage

>>> sv/ipv4_header_generate_top.sv
// ipv4 header generator: request register, header build with checksum, word buffer
// depends on ihg_pkg and assert_macros.svh
// datapath: an accepted request moves from the request register into an empty or finishing word buffer
// output: five header words per request; a new request can wait in the request register
//   while the buffer drains, and an error request yields one word
// reset: aresetn synchronous active low clears all valid flags and the word counter
`include "assert_macros.svh"

module ipv4_header_generate_top #(
    parameter int unsigned MAX_PAYLOAD = ihg_pkg::MAX_PAYLOAD_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ihg_pkg::addr_t s_source_address,
    input  ihg_pkg::addr_t s_destination_address,
    input  ihg_pkg::proto_t s_protocol_number,
    input  ihg_pkg::len_t  s_payload_length,
    output logic           m_valid,
    input  logic           m_ready,
    output ihg_pkg::word_t m_header_word,
    output logic           m_last_word,
    output logic           m_length_error
);
    import ihg_pkg::*;

    localparam len_t MAX_LEN = len_t'(MAX_PAYLOAD);

    // request register
    logic   req_valid_reg;
    addr_t  src_reg;
    addr_t  dst_reg;
    proto_t proto_reg;
    len_t   plen_reg;

    // header word buffer
    logic   buf_valid_reg;
    logic   err_reg;
    widx_t  idx_reg;
    word_t  words_reg [HDR_WORDS];

    logic   req_take;
    logic   buf_done;

    // header build
    logic        len_err;
    len_t        ip_total_len;
    logic [19:0] sum_wide;
    logic [16:0] sum_fold1;
    logic [16:0] sum_fold2;
    logic [15:0] csum;
    word_t       hdr_next [HDR_WORDS];

    assign len_err      = plen_reg > MAX_LEN;
    assign ip_total_len = HDR_BYTES + plen_reg;

    // one's-complement sum of the ten header halfwords, checksum field as zero
    assign sum_wide = 20'({HDR_VER_IHL, HDR_TOS}) + 20'(ip_total_len)
                    + 20'(HDR_ID) + 20'(HDR_DF_FLAG)
                    + 20'({HDR_TTL, proto_reg})
                    + 20'(src_reg[31:16]) + 20'(src_reg[15:0])
                    + 20'(dst_reg[31:16]) + 20'(dst_reg[15:0]);
    assign sum_fold1 = 17'(sum_wide[15:0]) + 17'(sum_wide[19:16]);
    assign sum_fold2 = 17'(sum_fold1[15:0]) + 17'(sum_fold1[16]);
    assign csum      = ~sum_fold2[15:0];

    always_comb begin
        hdr_next[0] = {HDR_VER_IHL, HDR_TOS, ip_total_len};
        hdr_next[1] = {HDR_ID, HDR_DF_FLAG};
        hdr_next[2] = {HDR_TTL, proto_reg, csum};
        hdr_next[3] = src_reg;
        hdr_next[4] = dst_reg;
    end

    // handshake control
    assign buf_done = m_valid && m_ready && m_last_word;
    assign req_take = req_valid_reg && (!buf_valid_reg || buf_done);
    assign s_ready  = !req_valid_reg || req_take;

    // request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_ready) begin
            req_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            src_reg   <= s_source_address;
            dst_reg   <= s_destination_address;
            proto_reg <= s_protocol_number;
            plen_reg  <= s_payload_length;
        end
    end

    // word buffer and position counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (req_take) begin
            buf_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end else if (buf_done) begin
            buf_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (m_valid && m_ready) begin
            idx_reg <= idx_reg + widx_t'(1);
        end
        if (req_take) begin
            err_reg <= len_err;
            for (int i = 0; i < HDR_WORDS; i++) begin
                words_reg[i] <= hdr_next[i];
            end
        end
    end

    // result outputs
    assign m_valid        = buf_valid_reg;
    assign m_header_word  = err_reg ? '0 : words_reg[idx_reg];
    assign m_last_word    = err_reg || (idx_reg == WIDX_LAST);
    assign m_length_error = err_reg;

    // checks
    `ASSERT_IMPLIES(a_err_single, m_valid && m_length_error,
                    m_last_word && (m_header_word == '0),
                    "error transaction must be a single zero word")
    `ASSERT_IMPLIES(a_idx_range, buf_valid_reg, idx_reg <= WIDX_LAST,
                    "word index past end of header")
    `ASSERT_NEXT(a_buf_fill, req_valid_reg && !buf_valid_reg,
                 buf_valid_reg && (idx_reg == '0),
                 "pending request not moved into empty buffer")

endmodule
